// ----- src/mmbs_pkg.sv -----
`default_nettype none

package mmbs_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int WIN_BITS    = 7;
   localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
   localparam int DIST_BITS   = ADDR_BITS + 1;
   localparam int CNT_BITS    = ADDR_BITS;
   localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS + 1;
   localparam int CMP_BITS    = SAMPLE_BITS + WIN_BITS + 1;

   localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(16);
   localparam logic [WIN_BITS-1:0] WINDOW_MIN   = WIN_BITS'(2);
   localparam logic [WIN_BITS-1:0] WINDOW_MAX   = WIN_BITS'(MAX_WINDOW);

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [DIST_BITS-1:0] dist_a;
      logic [DIST_BITS-1:0] dist_b;
   } line_cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CALC    = 6'b000010,
      ST_SUM_RD  = 6'b000100,
      ST_SUM_ACC = 6'b001000,
      ST_FL_RD   = 6'b010000,
      ST_FL_OUT  = 6'b100000
   } state_type;

   function automatic logic [WIN_BITS-1:0] eff_window(input logic [WIN_BITS-1:0] w);
      logic [WIN_BITS-1:0] r;
      if (w < WINDOW_MIN) begin
         r = WINDOW_MIN;
      end else if (w > WINDOW_MAX) begin
         r = WINDOW_MAX;
      end else begin
         r = w;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/mmbs_line.sv -----
`default_nettype none

module mmbs_line
   import mmbs_pkg::*;
(
   input  wire                            clock,
   input  wire                            reset,
   input  wire line_cmd_type              cmd,
   input  wire signed [SAMPLE_BITS-1:0]   wr_data,
   output logic signed [SAMPLE_BITS-1:0]  rd_a,
   output logic signed [SAMPLE_BITS-1:0]  rd_b
);

   logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
   logic [ADDR_BITS-1:0]          wp_ff;
   logic [ADDR_BITS-1:0]          wp_in;
   logic [ADDR_BITS-1:0]          addr_a;
   logic [ADDR_BITS-1:0]          addr_b;
   logic signed [SAMPLE_BITS-1:0] rd_a_ff;
   logic signed [SAMPLE_BITS-1:0] rd_b_ff;

   // entry k words back sits at wp - 1 - k, so a distance d reads wp - d
   assign addr_a = wp_ff - ADDR_BITS'(cmd.dist_a);
   assign addr_b = wp_ff - ADDR_BITS'(cmd.dist_b);
   assign wp_in  = cmd.wr_en ? wp_ff + ADDR_BITS'(1) : wp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   // read-first: a read of the slot being written returns the old word
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wp_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

`default_nettype wire

// ----- src/moving_mean_burst_slicer.sv -----
`default_nettype none

// Burst slicer: each burst sample gets a hard decision, 1 when sample*N exceeds the sum of the
// N samples of a window centered on it (N = csr_window_size, clamped to 2..64). Samples live in a
// 64-word circular memory with a registered read port. A burst word first writes the sample and
// reads the oldest and center words, then updates the running sum and decides. When the end
// word has tail decisions, the block then sums the newest m = min(ceil(N/2), fill) samples and
// gives up to ceil(N/2)-1 tail decisions, with one memory read for each sample summed and for
// each tail decision. A stalled result holds the block until it is taken. The first
// floor(N/2) samples of a burst give no decision. Words outside a burst are taken and dropped.
// A window write aborts any open burst; it is taken only while the block is idle, and input
// words are held off while it is offered.
module moving_mean_burst_slicer
   import mmbs_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire signed [SAMPLE_BITS-1:0] req_sample,
   input  wire                          req_burst_start,
   input  wire                          req_burst_end,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_decision,
   output logic                         rsp_last_of_burst,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [WIN_BITS-1:0]           csr_window_size
);

   state_type                     state_ff, state_in;
   logic [WIN_BITS-1:0]           window_size_ff, window_size_in;
   logic                          in_burst_ff, in_burst_in;
   logic [WIN_BITS-1:0]           fill_ff, fill_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SUM_BITS-1:0]    tail_ff, tail_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          end_ff, end_in;
   logic                          sub_ff, sub_in;
   logic [CNT_BITS-1:0]           m_ff, m_in;
   logic [CNT_BITS-1:0]           nflush_ff, nflush_in;
   logic [CNT_BITS-1:0]           idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_dec_ff, rsp_dec_in;
   logic                          rsp_last_ff, rsp_last_in;

   line_cmd_type                  cmd;
   logic signed [SAMPLE_BITS-1:0] rd_a;
   logic signed [SAMPLE_BITS-1:0] rd_b;

   logic [WIN_BITS-1:0]           n_eff;
   logic [WIN_BITS-1:0]           h_eff;
   logic [WIN_BITS-1:0]           c_eff;
   logic [WIN_BITS-1:0]           m_full;
   logic [WIN_BITS-1:0]           nflush_full;
   logic [WIN_BITS-1:0]           fill_base;
   logic                          req_take;
   logic                          csr_take;
   logic                          out_free;
   logic                          need_dec;
   logic signed [SUM_BITS-1:0]    sub_val;
   logic signed [SUM_BITS-1:0]    sum_new;
   logic signed [SAMPLE_BITS-1:0] mul_a;
   logic [WIN_BITS-1:0]           mul_b;
   logic signed [SUM_BITS-1:0]    cmp_rhs;
   logic signed [CMP_BITS-1:0]    prod;
   logic                          above;

   mmbs_line u_line (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_data (req_sample),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   assign n_eff = eff_window(window_size_ff);
   assign h_eff = n_eff >> 1;
   assign c_eff = n_eff - h_eff;

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // tail flush sizing from the fill after this word
   always_comb begin
      m_full = (c_eff < fill_ff) ? c_eff : fill_ff;
      nflush_full = '0;
      if (fill_ff > h_eff) begin
         nflush_full = fill_ff - h_eff;
         if (nflush_full > c_eff - WIN_BITS'(1)) begin
            nflush_full = c_eff - WIN_BITS'(1);
         end
      end
   end

   assign sub_val  = sub_ff ? SUM_BITS'(rd_a) : SUM_BITS'(0);
   assign sum_new  = sum_ff - sub_val + SUM_BITS'(x_ff);
   assign need_dec = (fill_ff == n_eff);

   // one shared multiplier for the centered and the tail test
   always_comb begin
      if (state_ff == ST_CALC) begin
         mul_a   = (c_eff == WIN_BITS'(1)) ? x_ff : rd_b;
         mul_b   = n_eff;
         cmp_rhs = sum_new;
      end else begin
         mul_a   = rd_a;
         mul_b   = WIN_BITS'(m_ff);
         cmp_rhs = tail_ff;
      end
   end

   assign prod  = $signed(CMP_BITS'(mul_a)) * $signed(CMP_BITS'(mul_b));
   assign above = prod > CMP_BITS'(cmp_rhs);

   always_comb begin
      state_in       = state_ff;
      window_size_in = window_size_ff;
      in_burst_in    = in_burst_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      tail_in        = tail_ff;
      x_in           = x_ff;
      end_in         = end_ff;
      sub_in         = sub_ff;
      m_in           = m_ff;
      nflush_in      = nflush_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_dec_in     = rsp_dec_ff;
      rsp_last_in    = rsp_last_ff;
      cmd            = '0;
      fill_base      = req_burst_start ? '0 : fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_burst_start || in_burst_ff)) begin
               cmd.wr_en   = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.dist_a  = DIST_BITS'(n_eff);
               cmd.dist_b  = DIST_BITS'(c_eff - WIN_BITS'(1));
               in_burst_in = 1'b1;
               x_in        = req_sample;
               end_in      = req_burst_end;
               sub_in      = (fill_base >= n_eff);
               fill_in     = (fill_base < n_eff) ? fill_base + WIN_BITS'(1) : fill_base;
               if (req_burst_start) begin
                  sum_in = '0;
               end
               state_in = ST_CALC;
            end
            if (csr_take) begin
               window_size_in = csr_window_size;
               in_burst_in    = 1'b0;
            end
         end
         ST_CALC: begin
            if (!need_dec || out_free) begin
               sum_in = sum_new;
               if (need_dec) begin
                  rsp_valid_in = 1'b1;
                  rsp_dec_in   = above;
                  rsp_last_in  = end_ff && (nflush_full == '0);
               end
               state_in = ST_IDLE;
               if (end_ff) begin
                  in_burst_in = 1'b0;
                  m_in        = CNT_BITS'(m_full);
                  nflush_in   = CNT_BITS'(nflush_full);
                  idx_in      = '0;
                  tail_in     = '0;
                  if (nflush_full != '0) begin
                     state_in = ST_SUM_RD;
                  end
               end
            end
         end
         ST_SUM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.dist_a = DIST_BITS'(idx_ff) + DIST_BITS'(1);
            state_in   = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            tail_in = tail_ff + SUM_BITS'(rd_a);
            if (idx_ff + CNT_BITS'(1) == m_ff) begin
               idx_in   = nflush_ff;
               state_in = ST_FL_RD;
            end else begin
               idx_in   = idx_ff + CNT_BITS'(1);
               state_in = ST_SUM_RD;
            end
         end
         ST_FL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.dist_a = DIST_BITS'(idx_ff);
            state_in   = ST_FL_OUT;
         end
         ST_FL_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dec_in   = above;
               rsp_last_in  = (idx_ff == CNT_BITS'(1));
               idx_in       = idx_ff - CNT_BITS'(1);
               state_in     = (idx_ff == CNT_BITS'(1)) ? ST_IDLE : ST_FL_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_size_ff <= WINDOW_RESET;
         in_burst_ff    <= 1'b0;
         fill_ff        <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         in_burst_ff    <= in_burst_in;
         fill_ff        <= fill_in;
         sum_ff         <= sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      x_ff        <= x_in;
      end_ff      <= end_in;
      sub_ff      <= sub_in;
      m_ff        <= m_in;
      nflush_ff   <= nflush_in;
      idx_ff      <= idx_in;
      rsp_dec_ff  <= rsp_dec_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decision      = rsp_dec_ff;
   assign rsp_last_of_burst = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      in_burst_ff |-> fill_ff <= n_eff)
      else $error("fill count beyond window");

   a_flush_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM_RD || state_ff == ST_SUM_ACC ||
       state_ff == ST_FL_RD || state_ff == ST_FL_OUT) |-> !in_burst_ff)
      else $error("tail flush while burst open");

   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM_RD || state_ff == ST_SUM_ACC) |->
      (nflush_ff < m_ff) && (nflush_ff != '0) && (idx_ff < m_ff))
      else $error("flush counts out of range");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FL_OUT && out_free && idx_ff == CNT_BITS'(1)) |=>
      rsp_valid_ff && rsp_last_ff && state_ff == ST_IDLE)
      else $error("final tail decision not marked last");

endmodule

`default_nettype wire
